FILE: rtl/hnm_pkg.sv
// hnm_pkg: sizes, types and codes shared by the histogram nearest match unit
// used by hnm_ref_mem, hnm_cell, hnm_ring and histogram_nearest_match_unit
package hnm_pkg;

	localparam int BINS    = 640;
	localparam int ENTRIES = 64;
	localparam int DEPTH   = ENTRIES * BINS;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(BINS + 1);
	localparam int ECNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 42;
	localparam int IDX_W  = 7;

	localparam logic [VAL_W-1:0] LIMIT_RESET = 16'd2560;
	localparam logic [IDX_W-1:0] IDX_NONE    = 7'h7F;
	localparam logic             KIND_REF    = 1'b0;
	localparam logic             KIND_QUERY  = 1'b1;

	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} ring_ctl_t;

endpackage

FILE: rtl/hnm_ref_mem.sv
// hnm_ref_mem: reference histogram store, one write and one registered read port
// depends on hnm_pkg
module hnm_ref_mem (
	input  logic          clk,
	input  logic          we,
	input  hnm_pkg::addr_t waddr,
	input  hnm_pkg::val_t  wdata,
	input  logic          re,
	input  hnm_pkg::addr_t raddr,
	output hnm_pkg::val_t  rdata
);
	import hnm_pkg::*;

	val_t mem_q [DEPTH];
	val_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/hnm_cell.sv
// hnm_cell: one distance accumulator of the rotating chain
// depends on hnm_pkg
module hnm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  hnm_pkg::ring_ctl_t ctl,
	input  hnm_pkg::acc_t      din,
	output hnm_pkg::acc_t      dout
);
	import hnm_pkg::*;

	acc_t acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= din;
		end
	end

	assign dout = acc_q;

endmodule

FILE: rtl/hnm_ring.sv
// hnm_ring: closed chain of accumulator cells, the tail value plus an addend re-enters at the head
// depends on hnm_pkg and hnm_cell
module hnm_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  hnm_pkg::ring_ctl_t ctl,
	input  hnm_pkg::prod_t     addend,
	output hnm_pkg::acc_t      tail
);
	import hnm_pkg::*;

	acc_t link [ENTRIES];
	acc_t head_in;

	assign head_in = link[ENTRIES-1] + ACC_W'(addend);
	assign tail    = link[ENTRIES-1];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			hnm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (head_in),
				.dout   (link[i])
			);
		end else begin : g_body
			hnm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (link[i-1]),
				.dout   (link[i])
			);
		end
	end

endmodule

FILE: rtl/histogram_nearest_match_unit.sv
// histogram_nearest_match_unit: top level, sequencer, distance pipeline and result register
// depends on hnm_pkg, hnm_ref_mem and hnm_ring
//
// A reference bin is written to the store in the cycle it is accepted, unless the library or the
// entry is full. A last reference bin then writes the missing bins as zero, one per cycle through
// the store's write port, and reports the cycle after. A query bin makes one store read per entry,
// then waits until the read and square pipeline has drained into the accumulator chain. A last
// query bin also runs a pass over the entries for each bin not supplied, then rotates the chain
// past the compare, and the answer appears the cycle after. done is high for one cycle per result
// and cannot be held off; busy is high while an item is in work, and start is taken only when low.
module histogram_nearest_match_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        kind,
	input  logic [15:0]                 bin_value,
	input  logic                        last_bin,
	input  logic                        match_limit_we,
	input  logic [15:0]                 match_limit_wdata,
	output logic                        done,
	output logic                        result_kind,
	output logic signed [6:0]           best_entry,
	output logic                        dropped
);
	import hnm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_ISSUE,
		ST_DRAIN,
		ST_SEARCH
	} state_t;

	state_t            state_q;
	val_t              match_limit_q;
	prod_t             limit2;
	logic [ECNT_W-1:0] entry_count_q;
	logic [CNT_W-1:0]  bin_counter_q;
	logic              open_kind_q;
	addr_t             base_q;
	logic [CNT_W-1:0]  fill_pos_q;
	logic [CNT_W-1:0]  pos_q;
	logic [ENT_W-1:0]  ent_q;
	addr_t             rd_addr_q;
	val_t              q_q;
	logic              qlast_q;
	acc_t              best_q;
	logic [IDX_W-1:0]  best_idx_q;

	logic              done_q;
	logic              result_kind_q;
	logic [IDX_W-1:0]  best_entry_q;
	logic              dropped_q;

	logic              valid_s1, live_s1;
	val_t              q_s1;
	logic              valid_s2;
	val_t              adiff_s2;
	logic              valid_s3;
	prod_t             prod_s3;

	logic              accept, restart, cnt_room, lib_full, pass_last, live_issue, better;
	logic [CNT_W-1:0]  eff_cnt, nxt_cnt;
	logic [IDX_W-1:0]  found_idx;
	ring_ctl_t         ring_ctl;
	prod_t             addend;
	acc_t              tail;
	logic              mem_we;
	addr_t             mem_waddr;
	val_t              mem_wdata;
	val_t              rd_data;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign restart    = (bin_counter_q != '0) && (kind != open_kind_q);
	assign eff_cnt    = restart ? '0 : bin_counter_q;
	assign cnt_room   = (eff_cnt < CNT_W'(BINS));
	assign nxt_cnt    = cnt_room ? eff_cnt + CNT_W'(1) : eff_cnt;
	assign lib_full   = (entry_count_q == ECNT_W'(ENTRIES));
	assign pass_last  = (ent_q == ENT_W'(ENTRIES - 1));
	assign live_issue = (ECNT_W'(ent_q) < entry_count_q);
	assign better     = live_issue && (tail < best_q);
	assign found_idx  = better ? IDX_W'(ent_q) : best_idx_q;
	assign limit2     = match_limit_q * match_limit_q;

	assign ring_ctl.clear = (accept && restart)
		|| ((state_q == ST_SEARCH) && pass_last);
	assign ring_ctl.shift = valid_s3 || (state_q == ST_SEARCH);
	assign addend         = valid_s3 ? prod_s3 : '0;

	assign mem_we    = (accept && (kind == KIND_REF) && !lib_full && cnt_room)
		|| (state_q == ST_FILL);
	assign mem_waddr = (state_q == ST_FILL) ? base_q + ADDR_W'(fill_pos_q)
		: base_q + ADDR_W'(eff_cnt);
	assign mem_wdata = (state_q == ST_FILL) ? '0 : bin_value;

	hnm_ref_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (state_q == ST_ISSUE),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	hnm_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.addend (addend),
		.tail   (tail)
	);

	always_ff @(posedge clk) begin
		live_s1  <= live_issue;
		q_s1     <= q_q;
		if (live_s1) begin
			adiff_s2 <= (q_s1 >= rd_data) ? q_s1 - rd_data : rd_data - q_s1;
		end else begin
			adiff_s2 <= '0;
		end
		prod_s3 <= adiff_s2 * adiff_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_ISSUE);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			match_limit_q <= LIMIT_RESET;
			entry_count_q <= '0;
			bin_counter_q <= '0;
			open_kind_q   <= KIND_REF;
			base_q        <= '0;
			fill_pos_q    <= '0;
			pos_q         <= '0;
			ent_q         <= '0;
			rd_addr_q     <= '0;
			q_q           <= '0;
			qlast_q       <= 1'b0;
			best_q        <= '0;
			best_idx_q    <= IDX_NONE;
			done_q        <= 1'b0;
			result_kind_q <= KIND_REF;
			best_entry_q  <= IDX_NONE;
			dropped_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (match_limit_we) begin
				match_limit_q <= match_limit_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						open_kind_q <= kind;
						if (kind == KIND_REF) begin
							if (!last_bin) begin
								bin_counter_q <= nxt_cnt;
							end else begin
								bin_counter_q <= '0;
								if (lib_full) begin
									done_q        <= 1'b1;
									result_kind_q <= KIND_REF;
									best_entry_q  <= IDX_NONE;
									dropped_q     <= 1'b1;
								end else if (nxt_cnt < CNT_W'(BINS)) begin
									fill_pos_q <= nxt_cnt;
									state_q    <= ST_FILL;
								end else begin
									done_q        <= 1'b1;
									result_kind_q <= KIND_REF;
									best_entry_q  <= IDX_W'(entry_count_q);
									dropped_q     <= 1'b0;
									entry_count_q <= entry_count_q + ECNT_W'(1);
									base_q        <= base_q + ADDR_W'(BINS);
								end
							end
						end else begin
							qlast_q <= last_bin;
							if (cnt_room) begin
								pos_q         <= eff_cnt;
								q_q           <= bin_value;
								ent_q         <= '0;
								rd_addr_q     <= ADDR_W'(eff_cnt);
								bin_counter_q <= last_bin ? '0 : nxt_cnt;
								state_q       <= ST_ISSUE;
							end else if (last_bin) begin
								bin_counter_q <= '0;
								ent_q         <= '0;
								best_q        <= ACC_W'(limit2);
								best_idx_q    <= IDX_NONE;
								state_q       <= ST_SEARCH;
							end else begin
								bin_counter_q <= eff_cnt;
							end
						end
					end
				end
				ST_FILL: begin
					if (fill_pos_q == CNT_W'(BINS - 1)) begin
						done_q        <= 1'b1;
						result_kind_q <= KIND_REF;
						best_entry_q  <= IDX_W'(entry_count_q);
						dropped_q     <= 1'b0;
						entry_count_q <= entry_count_q + ECNT_W'(1);
						base_q        <= base_q + ADDR_W'(BINS);
						state_q       <= ST_IDLE;
					end else begin
						fill_pos_q <= fill_pos_q + CNT_W'(1);
					end
				end
				ST_ISSUE: begin
					if (pass_last) begin
						if (qlast_q && (pos_q != CNT_W'(BINS - 1))) begin
							// missing query bins count as zero
							pos_q     <= pos_q + CNT_W'(1);
							rd_addr_q <= ADDR_W'(pos_q + CNT_W'(1));
							q_q       <= '0;
							ent_q     <= '0;
						end else begin
							state_q <= ST_DRAIN;
						end
					end else begin
						ent_q     <= ent_q + ENT_W'(1);
						rd_addr_q <= rd_addr_q + ADDR_W'(BINS);
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2 && !valid_s3) begin
						if (qlast_q) begin
							ent_q      <= '0;
							best_q     <= ACC_W'(limit2);
							best_idx_q <= IDX_NONE;
							state_q    <= ST_SEARCH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SEARCH: begin
					if (better) begin
						best_q     <= tail;
						best_idx_q <= IDX_W'(ent_q);
					end
					if (pass_last) begin
						done_q        <= 1'b1;
						result_kind_q <= KIND_QUERY;
						best_entry_q  <= found_idx;
						dropped_q     <= 1'b0;
						bin_counter_q <= '0;
						state_q       <= ST_IDLE;
					end else begin
						ent_q <= ent_q + ENT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign result_kind = result_kind_q;
	assign best_entry  = best_entry_q;
	assign dropped     = dropped_q;

endmodule
